// ===== hdl/scp_pkg.sv =====
// Shared types, character codes and helpers for the source character preprocessor.
// No dependencies; imported by every module of the block.
package scp_pkg;

    localparam int SEED_MAX_CHARS_DEF = 8;
    localparam int HELD_DEPTH         = 5;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_D   = 8'h44;

    localparam logic CFG_SEED_CHARS  = 1'b0;
    localparam logic CFG_SEED_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_ESC,
        SP_SEED
    } t_spec;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BYTES,
        BK_SPECIAL,
        BK_NEWLINE
    } t_bk_state;

    // One classified input byte: plain bytes to expand, then an optional escape
    // value or seed, then an optional final newline.
    typedef struct packed {
        logic [HELD_DEPTH-1:0][7:0] bytes;
        logic [2:0]                 nbytes;
        t_spec                      spec;
        logic [15:0]                esc;
        logic                       last;
    } t_job;

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

// ===== hdl/source_char_preprocessor.sv =====
// Source character preprocessor, top level: seed registers, front end,
// job queue and back end. Depends on scp_pkg, scp_front, scp_queue, scp_back.
// Throughput: one byte per cycle while each byte yields one character and the output
// is not stalled; a byte that yields several characters (tab, seed, flush, final newline)
// holds the back end until all of them are out.
// Reset (synchronous, active low) clears the held prefix, the queue and both seed registers.
module source_char_preprocessor
    import scp_pkg::*;
#(
    parameter int SEED_MAX_CHARS = SEED_MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_char,
    output logic        o_out_last
);

    logic [SEED_MAX_CHARS*8-1:0] r_seed_chars;
    logic [3:0]                  r_seed_len;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_push;
    logic                        q_pop;
    t_job                        front_job;
    t_job                        q_head;

    assign o_cfg_ready = 1'b1;

    // saturate the seed length on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_chars <= '0;
            r_seed_len   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED_CHARS: begin
                    r_seed_chars <= i_cfg_data[SEED_MAX_CHARS*8-1:0];
                end
                CFG_SEED_LENGTH: begin
                    r_seed_len <= (i_cfg_data[3:0] > 4'(SEED_MAX_CHARS)) ?
                                  4'(SEED_MAX_CHARS) : i_cfg_data[3:0];
                end
                default: begin
                    r_seed_len <= r_seed_len;
                end
            endcase
        end
    end

    scp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .i_seed_len (r_seed_len),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    scp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    scp_back #(
        .SEED_MAX_CHARS (SEED_MAX_CHARS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .i_seed_chars (r_seed_chars),
        .i_seed_len   (r_seed_len),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_char   (o_out_char),
        .o_out_last   (o_out_last)
    );

endmodule

// ===== hdl/scp_front.sv =====
// Front end: holds partial escape and seed prefixes and turns each input
// byte into at most one job for the back end. Depends on scp_pkg.
module scp_front
    import scp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_q_full,
    input  logic [3:0]  i_seed_len,
    output logic        o_in_stall,
    output logic        o_push,
    output t_job        o_job
);

    logic [7:0] r_held [HELD_DEPTH];
    logic [7:0] n_held [HELD_DEPTH];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    t_job       job;
    logic       accept;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // An invalid digit sets its nibble and every nibble above it.
    function automatic logic [15:0] esc_value(input logic [3:0][7:0] d);
        logic [4:0]  h;
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            h = hex_decode(d[k]);
            if (h[4]) begin
                r = r | (16'(h[3:0]) << (4 * k));
            end else begin
                r = r | (16'hFFFF << (4 * k));
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] seed_letter(input logic [2:0] cnt);
        logic [7:0] c;
        case (cnt)
            3'd1:    c = CH_UP_S;
            3'd2:    c = CH_UP_E;
            3'd3:    c = CH_UP_E;
            3'd4:    c = CH_UP_D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        logic [2:0] pn;
        logic       fresh;
        logic [7:0] b;
        n_held = r_held;
        n_cnt  = r_cnt;
        job    = '0;
        pn     = '0;
        fresh  = 1'b0;
        b      = i_in_byte;

        if (r_cnt == 3'd0 || r_cnt > 3'(HELD_DEPTH)) begin
            n_cnt = '0;
            fresh = 1'b1;
        end else if (r_held[0] == CH_BSLASH) begin
            if (r_cnt == 3'd1) begin
                if (b == CH_U) begin
                    n_held[1] = b;
                    n_cnt     = 3'd2;
                end else begin
                    n_cnt             = '0;
                    job.bytes[pn]     = CH_BSLASH;
                    pn                = pn + 3'd1;
                    fresh             = 1'b1;
                end
            end else if (r_cnt < 3'(HELD_DEPTH)) begin
                n_held[r_cnt] = b;
                n_cnt         = r_cnt + 3'd1;
            end else begin
                job.spec = SP_ESC;
                job.esc  = esc_value({r_held[2], r_held[3], r_held[4], b});
                n_cnt    = '0;
            end
        end else begin
            if (r_cnt <= 3'd4 && b == seed_letter(r_cnt)) begin
                if (r_cnt == 3'd4) begin
                    n_cnt = '0;
                    if (i_seed_len != 4'd0) begin
                        job.spec = SP_SEED;
                    end
                end else begin
                    n_held[r_cnt] = b;
                    n_cnt         = r_cnt + 3'd1;
                end
            end else begin
                // mismatch: flush the held prefix literally
                for (int i = 0; i < HELD_DEPTH; i++) begin
                    if (3'(i) < r_cnt && r_held[i] != CH_CR && pn < 3'(HELD_DEPTH)) begin
                        job.bytes[pn] = r_held[i];
                        pn            = pn + 3'd1;
                    end
                end
                n_cnt = '0;
                fresh = 1'b1;
            end
        end

        if (fresh) begin
            if (b == CH_BSLASH || b == CH_DOLLAR) begin
                n_held[0] = b;
                n_cnt     = 3'd1;
            end else if (b != CH_CR && pn < 3'(HELD_DEPTH)) begin
                job.bytes[pn] = b;
                pn            = pn + 3'd1;
            end
        end

        if (i_in_last) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (3'(i) < n_cnt && n_held[i] != CH_CR && pn < 3'(HELD_DEPTH)) begin
                    job.bytes[pn] = n_held[i];
                    pn            = pn + 3'd1;
                end
            end
            n_cnt    = '0;
            job.last = 1'b1;
        end

        job.nbytes = pn;
    end

    assign o_job  = job;
    assign o_push = accept && (job.nbytes != 3'd0 || job.spec != SP_NONE || job.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

// ===== hdl/scp_queue.sv =====
// Short job queue between the front and back ends.
// Depends on scp_pkg for the job type and depth.
module scp_queue
    import scp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("job queue count missed a transfer");

endmodule

// ===== hdl/scp_back.sv =====
// Back end: expands queued jobs into 16-bit characters, one per cycle while the output
// is not stalled, through an output register. Depends on scp_pkg.
module scp_back
    import scp_pkg::*;
#(
    parameter int SEED_MAX_CHARS = SEED_MAX_CHARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  t_job                        i_q_head,
    output logic                        o_q_pop,
    input  logic [SEED_MAX_CHARS*8-1:0] i_seed_chars,
    input  logic [3:0]                  i_seed_len,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [15:0]                 o_out_char,
    output logic                        o_out_last
);

    localparam int SIDX_W = (SEED_MAX_CHARS > 1) ? $clog2(SEED_MAX_CHARS) : 1;

    t_bk_state         r_state;
    t_bk_state         n_state;
    t_job              r_job;
    logic [2:0]        r_idx;
    logic [2:0]        n_idx;
    logic              r_half;
    logic              n_half;
    logic [SIDX_W-1:0] r_sidx;
    logic [SIDX_W-1:0] n_sidx;
    logic              r_out_valid;
    logic [15:0]       r_out_char;
    logic              r_out_last;

    logic              ld;
    logic              load;
    logic [7:0]        cur_byte;
    logic              is_tab;
    logic [15:0]       cur_char;
    logic              cur_last;
    logic              phase_done;

    function automatic t_bk_state first_state(input t_job j);
        t_bk_state s;
        if (j.nbytes != 3'd0) begin
            s = BK_BYTES;
        end else if (j.spec != SP_NONE) begin
            s = BK_SPECIAL;
        end else begin
            s = BK_NEWLINE;
        end
        return s;
    endfunction

    assign ld       = !r_out_valid || !i_out_stall;
    assign cur_byte = r_job.bytes[r_idx];
    assign is_tab   = (cur_byte == CH_TAB);

    // output logic: character of the current step
    always_comb begin
        cur_char   = '0;
        cur_last   = 1'b0;
        phase_done = 1'b0;
        case (r_state)
            BK_BYTES: begin
                cur_char   = is_tab ? {8'h00, CH_SPACE} : sext8(cur_byte);
                phase_done = (!is_tab || r_half) && (r_idx == r_job.nbytes - 3'd1);
            end
            BK_SPECIAL: begin
                if (r_job.spec == SP_ESC) begin
                    cur_char   = r_job.esc;
                    phase_done = 1'b1;
                end else begin
                    cur_char   = sext8(i_seed_chars[8*r_sidx +: 8]);
                    phase_done = (4'(r_sidx) + 4'd1 == i_seed_len);
                end
            end
            BK_NEWLINE: begin
                cur_char   = {8'h00, CH_LF};
                cur_last   = 1'b1;
                phase_done = 1'b1;
            end
            default: begin
                cur_char   = '0;
                cur_last   = 1'b0;
                phase_done = 1'b0;
            end
        endcase
    end

    // next state and step counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_half  = r_half;
        n_sidx  = r_sidx;
        load    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                load = i_q_valid;
            end
            BK_BYTES: begin
                if (ld) begin
                    if (phase_done) begin
                        n_idx  = '0;
                        n_half = 1'b0;
                        if (r_job.spec != SP_NONE) begin
                            n_state = BK_SPECIAL;
                        end else if (r_job.last) begin
                            n_state = BK_NEWLINE;
                        end else begin
                            n_state = BK_IDLE;
                            load    = i_q_valid;
                        end
                    end else if (is_tab && !r_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        n_idx  = r_idx + 3'd1;
                    end
                end
            end
            BK_SPECIAL: begin
                if (ld) begin
                    if (phase_done) begin
                        n_sidx = '0;
                        if (r_job.last) begin
                            n_state = BK_NEWLINE;
                        end else begin
                            n_state = BK_IDLE;
                            load    = i_q_valid;
                        end
                    end else begin
                        n_sidx = r_sidx + SIDX_W'(1);
                    end
                end
            end
            BK_NEWLINE: begin
                if (ld) begin
                    n_state = BK_IDLE;
                    load    = i_q_valid;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (load) begin
            n_state = first_state(i_q_head);
            n_idx   = '0;
            n_half  = 1'b0;
            n_sidx  = '0;
        end
    end

    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_half      <= 1'b0;
            r_sidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_half  <= n_half;
            r_sidx  <= n_sidx;
            if (ld) begin
                r_out_valid <= (r_state != BK_IDLE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_head;
        end
        if (ld) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule
